// ===== sv/slcg_pkg.sv =====
// Shared types, constants and small arithmetic helpers for the status LED color generator.
// No dependencies; used by slcg_mod_unit, slcg_div_unit and status_led_color_generator_top.
package slcg_pkg;

    // field widths
    localparam int NOW_W      = 32;
    localparam int LVL_W      = 8;
    localparam int PCT_W      = 8;
    localparam int OVL_W      = 7;
    localparam int MODE_W     = 3;
    localparam int LAMP_W     = 7;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 5;

    // serial remainder unit: holds values below the largest period
    localparam int REM_W = 12;
    // serial divider: dividend/quotient and divisor widths
    localparam int DIV_Q_W = 19;
    localparam int DIV_D_W = 11;
    localparam int TRI_W   = 11;

    localparam logic [CNT_W-1:0] MOD_LAST_STEP = CNT_W'(NOW_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(DIV_Q_W - 1);

    // timing constants (ms)
    localparam logic [REM_W-1:0] PERIOD_BREATHE = REM_W'(3000);
    localparam logic [REM_W-1:0] HALF_BREATHE   = REM_W'(1500);
    localparam logic [REM_W-1:0] PERIOD_PULSE   = REM_W'(2000);
    localparam logic [REM_W-1:0] HALF_PULSE     = REM_W'(1000);
    localparam logic [REM_W-1:0] PERIOD_BLINK   = REM_W'(500);
    localparam logic [REM_W-1:0] BLINK_ON_MS    = REM_W'(250);

    localparam logic [OVL_W-1:0] PCT_FULL = OVL_W'(100);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_HOLD    = 2'd2;

    localparam logic [LVL_W-1:0]      MAX_LEVEL_RST = 8'd40;
    localparam logic [CFG_DATA_W-1:0] INTERVAL_RST  = 16'd17;
    localparam logic [CFG_DATA_W-1:0] HOLD_RST      = 16'd500;

    // word kinds
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_OVERLAY = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_MANUAL = 3'd0,
        MODE_DRIVE  = 3'd1,
        MODE_TURN   = 3'd2,
        MODE_CHASE  = 3'd3,
        MODE_SEQ    = 3'd4,
        MODE_PULSE  = 3'd5,
        MODE_ALT    = 3'd6,
        MODE_DARK   = 3'd7
    } mode_t;

    typedef struct packed {
        logic load;
        logic step;
    } mod_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    // Q0.16 gamma 2.2 curve, percent 0..99
    localparam logic [15:0] GAMMA_Q16 [100] = '{
        16'd0,     16'd3,     16'd12,    16'd29,    16'd55,
        16'd90,    16'd134,   16'd189,   16'd253,   16'd328,
        16'd414,   16'd510,   16'd618,   16'd736,   16'd867,
        16'd1009,  16'd1163,  16'd1329,  16'd1507,  16'd1697,
        16'd1900,  16'd2115,  16'd2343,  16'd2584,  16'd2837,
        16'd3104,  16'd3384,  16'd3677,  16'd3983,  16'd4303,
        16'd4636,  16'd4983,  16'd5343,  16'd5718,  16'd6106,
        16'd6508,  16'd6924,  16'd7354,  16'd7798,  16'd8257,
        16'd8730,  16'd9217,  16'd9719,  16'd10236, 16'd10766,
        16'd11312, 16'd11873, 16'd12448, 16'd13038, 16'd13643,
        16'd14263, 16'd14898, 16'd15549, 16'd16214, 16'd16894,
        16'd17590, 16'd18302, 16'd19028, 16'd19771, 16'd20528,
        16'd21302, 16'd22091, 16'd22895, 16'd23715, 16'd24551,
        16'd25402, 16'd26270, 16'd27154, 16'd28054, 16'd28970,
        16'd29902, 16'd30850, 16'd31814, 16'd32793, 16'd33790,
        16'd34803, 16'd35831, 16'd36877, 16'd37939, 16'd39018,
        16'd40112, 16'd41224, 16'd42352, 16'd43496, 16'd44657,
        16'd45835, 16'd47030, 16'd48242, 16'd49470, 16'd50715,
        16'd51977, 16'd53256, 16'd54552, 16'd55865, 16'd57195,
        16'd58543, 16'd59907, 16'd61288, 16'd62687, 16'd64103
    };

    function automatic logic [15:0] gamma_lookup(input logic [OVL_W-1:0] lvl);
        logic [15:0] g;
        g = (lvl < PCT_FULL) ? GAMMA_Q16[lvl] : 16'd0;
        return g;
    endfunction

    // x / 5 for x below 1024, by reciprocal multiply
    function automatic logic [LVL_W-1:0] div5(input logic [9:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return p[17:10];
    endfunction

    // m * 80 / 100
    function automatic logic [LVL_W-1:0] pct80(input logic [LVL_W-1:0] m);
        return div5({m, 2'b00});
    endfunction

    // m * 60 / 100
    function automatic logic [LVL_W-1:0] pct60(input logic [LVL_W-1:0] m);
        logic [9:0] three_m;
        three_m = {2'b00, m} + {1'b0, m, 1'b0};
        return div5(three_m);
    endfunction

    // m * 45 / 100 = floor(floor(9m/4)/5)
    function automatic logic [LVL_W-1:0] pct45(input logic [LVL_W-1:0] m);
        logic [11:0] nine_m;
        nine_m = {4'b0000, m} + {1'b0, m, 3'b000};
        return div5(nine_m[11:2]);
    endfunction

    // m / 3
    function automatic logic [LVL_W-1:0] third(input logic [LVL_W-1:0] m);
        logic [15:0] p;
        p = 16'(m) * 16'd171;
        return {1'b0, p[15:9]};
    endfunction

endpackage

// ===== sv/status_led_color_generator_top.sv =====
// Status LED color generator: sequencer, state and output register.
// Depends on slcg_pkg, slcg_mod_unit and slcg_div_unit.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  s_axis  | in        | s_axis_tvalid/s_axis_tready | tdata: item fields, tuser: action
//  m_axis  | out       | m_axis_tvalid/m_axis_tready | tdata: red, green, blue
//  cfg     | in        | cfg_wr_en (no wait)         | cfg_index, cfg_data
//
// One word at a time. An overlay word only updates the overlay state; a tick that comes too
// early is dropped after the interval check. Overlay red or green, drive, dark and connected
// manual are set in ST_OVL and then handed off; overlay white passes through ST_WHITE too.
// Blink modes add the 32-step serial remainder of now_ms (ST_MOD, then ST_TRI). Manual
// breathing runs the remainder and then one 19-step serial divide; pulse runs two divides.
// A finished color waits in the output register; the next word is taken meanwhile, and
// only the hand-off state waits for m_axis_tready.
// rst_n clears state, config registers (to their defaults) and the output valid.
module status_led_color_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // now_ms[31:0], overlay_pct[39:32], mode[42:40], client_connected[43],
    // stop_pct[50:44], reverse_pct[57:51], turn_pct[64:58], marker_pct[71:65]
    input  logic [slcg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action[0]
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [slcg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic [slcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slcg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_OVL,
        ST_WHITE,
        ST_MOD,
        ST_TRI,
        ST_DIV,
        ST_DIV_END
    } state_t;
    // hand-off tracked apart from the sequencer
    typedef enum logic {
        HO_IDLE,
        HO_PENDING
    } handoff_t;

    state_t   state_reg, state_next;
    handoff_t ho_reg, ho_next;

    logic [slcg_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            div_pass_reg, div_pass_next;

    // latched tick word
    logic [slcg_pkg::NOW_W-1:0]      now_reg, now_next;
    slcg_pkg::mode_t                 mode_reg, mode_next;
    logic                            client_reg, client_next;
    logic                            stop_on_reg, stop_on_next;
    logic                            rev_on_reg, rev_on_next;
    logic                            turn_on_reg, turn_on_next;
    logic                            mark_on_reg, mark_on_next;

    // block state
    logic [slcg_pkg::NOW_W-1:0]      last_frame_reg, last_frame_next;
    logic [slcg_pkg::OVL_W-1:0]      ovl_level_reg, ovl_level_next;
    logic [slcg_pkg::NOW_W-1:0]      ovl_end_reg, ovl_end_next;

    // config
    logic [slcg_pkg::LVL_W-1:0]      max_level_reg, max_level_next;
    logic [slcg_pkg::CFG_DATA_W-1:0] interval_reg, interval_next;
    logic [slcg_pkg::CFG_DATA_W-1:0] hold_reg, hold_next;

    // color being built, then output register
    logic [slcg_pkg::LVL_W-1:0]      res_r_reg, res_r_next;
    logic [slcg_pkg::LVL_W-1:0]      res_g_reg, res_g_next;
    logic [slcg_pkg::LVL_W-1:0]      res_b_reg, res_b_next;
    logic                            out_valid_reg, out_valid_next;
    logic [slcg_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // serial units
    slcg_pkg::mod_ctl_t              mod_ctl;
    logic [slcg_pkg::REM_W-1:0]      modulus;
    logic [slcg_pkg::REM_W-1:0]      phase;
    slcg_pkg::div_ctl_t              div_ctl;
    logic [slcg_pkg::DIV_Q_W-1:0]    div_dividend;
    logic [slcg_pkg::DIV_D_W-1:0]    div_divisor;
    logic [slcg_pkg::DIV_Q_W-1:0]    div_quotient;

    // combinational helpers
    logic                            in_fire;
    logic                            out_free;
    logic [slcg_pkg::LVL_W-1:0]      m;
    logic [slcg_pkg::NOW_W-1:0]      elapsed;
    logic [slcg_pkg::NOW_W-1:0]      ovl_diff;
    logic                            ovl_active;
    logic [slcg_pkg::PCT_W-1:0]      in_pct;
    logic [23:0]                     white_prod;
    logic [slcg_pkg::LVL_W-1:0]      white;
    logic [slcg_pkg::REM_W-1:0]      half;
    logic [slcg_pkg::REM_W-1:0]      period;
    logic [slcg_pkg::REM_W-1:0]      tri_wide;
    logic [slcg_pkg::TRI_W-1:0]      tri_val;
    logic                            blink_on;
    logic [slcg_pkg::LVL_W-1:0]      q8;
    logic [15:0]                     pulse_red_prod;

    assign m        = max_level_reg;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign in_pct   = s_axis_tdata[39:32];

    assign elapsed    = now_reg - last_frame_reg;
    assign ovl_diff   = ovl_end_reg - now_reg;
    assign ovl_active = (ovl_diff != '0) && !ovl_diff[slcg_pkg::NOW_W-1];

    // overlay white: round(gamma * max), never below 1
    assign white_prod = 24'(slcg_pkg::gamma_lookup(ovl_level_reg)) * 24'(m) + 24'd32768;
    assign white      = (white_prod[23:16] == '0) ? 8'd1 : white_prod[23:16];

    // triangle of the remainder
    always_comb
    begin
        if (mode_reg == slcg_pkg::MODE_MANUAL)
        begin
            half   = slcg_pkg::HALF_BREATHE;
            period = slcg_pkg::PERIOD_BREATHE;
        end
        else
        begin
            half   = slcg_pkg::HALF_PULSE;
            period = slcg_pkg::PERIOD_PULSE;
        end
        tri_wide = (phase < half) ? phase : (period - phase);
    end
    assign tri_val  = tri_wide[slcg_pkg::TRI_W-1:0];
    assign blink_on = (phase < slcg_pkg::BLINK_ON_MS);
    assign q8       = div_quotient[slcg_pkg::LVL_W-1:0];
    // pulse red = (max*60/100) * br / max, br straight from the first divide
    assign pulse_red_prod = 16'(slcg_pkg::pct60(m)) * 16'(q8);

    always_comb
    begin
        unique case (mode_reg)
            slcg_pkg::MODE_MANUAL: modulus = slcg_pkg::PERIOD_BREATHE;
            slcg_pkg::MODE_PULSE:  modulus = slcg_pkg::PERIOD_PULSE;
            default:               modulus = slcg_pkg::PERIOD_BLINK;
        endcase
    end

    assign mod_ctl.load = (state_reg == ST_OVL);
    assign mod_ctl.step = (state_reg == ST_MOD);

    slcg_mod_unit u_mod (
        .clk       (clk),
        .ctl       (mod_ctl),
        .value     (now_reg),
        .modulus   (modulus),
        .remainder (phase)
    );

    // divider load: breathing/pulse brightness first, pulse red on the second pass
    always_comb
    begin
        div_ctl.load = 1'b0;
        div_ctl.step = (state_reg == ST_DIV);
        div_dividend = slcg_pkg::DIV_Q_W'(tri_val) * slcg_pkg::DIV_Q_W'(m);
        div_divisor  = (mode_reg == slcg_pkg::MODE_MANUAL) ? slcg_pkg::DIV_D_W'(1500)
                                                          : slcg_pkg::DIV_D_W'(1000);
        if (state_reg == ST_TRI)
        begin
            div_ctl.load = (mode_reg == slcg_pkg::MODE_MANUAL)
                        || (mode_reg == slcg_pkg::MODE_PULSE);
        end
        else if (state_reg == ST_DIV_END)
        begin
            div_ctl.load = !div_pass_reg && (mode_reg == slcg_pkg::MODE_PULSE);
            div_dividend = slcg_pkg::DIV_Q_W'(pulse_red_prod);
            div_divisor  = slcg_pkg::DIV_D_W'(m);
        end
    end

    slcg_div_unit u_div (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient)
    );

    assign s_axis_tready = (state_reg == ST_IDLE) && (ho_reg == HO_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        ho_next         = ho_reg;
        cnt_next        = cnt_reg;
        div_pass_next   = div_pass_reg;
        now_next        = now_reg;
        mode_next       = mode_reg;
        client_next     = client_reg;
        stop_on_next    = stop_on_reg;
        rev_on_next     = rev_on_reg;
        turn_on_next    = turn_on_reg;
        mark_on_next    = mark_on_reg;
        last_frame_next = last_frame_reg;
        ovl_level_next  = ovl_level_reg;
        ovl_end_next    = ovl_end_reg;
        max_level_next  = max_level_reg;
        interval_next   = interval_reg;
        hold_next       = hold_reg;
        res_r_next      = res_r_reg;
        res_g_next      = res_g_reg;
        res_b_next      = res_b_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // hand-off of a finished color into the output register
        unique case (ho_reg)
            HO_PENDING:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_b_reg, res_g_reg, res_r_reg};
                    ho_next        = HO_IDLE;
                end
            end
            default: ;
        endcase

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                slcg_pkg::CFG_MAX_LEVEL:       max_level_next = cfg_data[slcg_pkg::LVL_W-1:0];
                slcg_pkg::CFG_UPDATE_INTERVAL: interval_next  = cfg_data;
                slcg_pkg::CFG_OVERLAY_HOLD:    hold_next      = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser[0] == slcg_pkg::ACT_OVERLAY)
                    begin
                        ovl_level_next = (in_pct > 8'(slcg_pkg::PCT_FULL))
                                       ? slcg_pkg::PCT_FULL : in_pct[slcg_pkg::OVL_W-1:0];
                        ovl_end_next   = s_axis_tdata[31:0] + slcg_pkg::NOW_W'(hold_reg);
                    end
                    else
                    begin
                        now_next     = s_axis_tdata[31:0];
                        mode_next    = slcg_pkg::mode_t'(s_axis_tdata[42:40]);
                        client_next  = s_axis_tdata[43];
                        stop_on_next = (s_axis_tdata[50:44] != '0);
                        rev_on_next  = (s_axis_tdata[57:51] != '0);
                        turn_on_next = (s_axis_tdata[64:58] != '0);
                        mark_on_next = (s_axis_tdata[71:65] != '0);
                        state_next   = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (elapsed < slcg_pkg::NOW_W'(interval_reg))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    last_frame_next = now_reg;
                    state_next      = ST_OVL;
                end
            end

            ST_OVL:
            begin
                res_r_next = '0;
                res_g_next = '0;
                res_b_next = '0;
                state_next = ST_IDLE;
                if (ovl_active)
                begin
                    if (ovl_level_reg == '0)
                    begin
                        res_r_next = m;
                        ho_next    = HO_PENDING;
                    end
                    else if (ovl_level_reg >= slcg_pkg::PCT_FULL)
                    begin
                        res_g_next = m;
                        ho_next    = HO_PENDING;
                    end
                    else
                    begin
                        state_next = ST_WHITE;
                    end
                end
                else
                begin
                    case (mode_reg)
                        slcg_pkg::MODE_MANUAL:
                        begin
                            if (client_reg)
                            begin
                                res_g_next = m;
                                ho_next    = HO_PENDING;
                            end
                            else
                            begin
                                cnt_next   = slcg_pkg::MOD_LAST_STEP;
                                state_next = ST_MOD;
                            end
                        end
                        slcg_pkg::MODE_DRIVE:
                        begin
                            // turn beats reverse beats stop beats marker
                            if (turn_on_reg)
                            begin
                                res_r_next = m;
                                res_g_next = slcg_pkg::pct80(m);
                            end
                            else if (rev_on_reg)
                            begin
                                res_r_next = m;
                                res_g_next = m;
                                res_b_next = m;
                            end
                            else if (stop_on_reg)
                            begin
                                res_r_next = m;
                            end
                            else if (mark_on_reg)
                            begin
                                res_r_next = slcg_pkg::third(m);
                                res_g_next = slcg_pkg::third(m);
                                res_b_next = slcg_pkg::third(m);
                            end
                            ho_next = HO_PENDING;
                        end
                        slcg_pkg::MODE_DARK:
                        begin
                            ho_next = HO_PENDING;
                        end
                        default:
                        begin
                            cnt_next   = slcg_pkg::MOD_LAST_STEP;
                            state_next = ST_MOD;
                        end
                    endcase
                end
            end

            ST_WHITE:
            begin
                res_r_next = white;
                res_g_next = white;
                res_b_next = white;
                ho_next    = HO_PENDING;
                state_next = ST_IDLE;
            end

            ST_MOD:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_TRI;
                end
            end

            ST_TRI:
            begin
                if ((mode_reg == slcg_pkg::MODE_MANUAL) || (mode_reg == slcg_pkg::MODE_PULSE))
                begin
                    cnt_next      = slcg_pkg::DIV_LAST_STEP;
                    div_pass_next = 1'b0;
                    state_next    = ST_DIV;
                end
                else
                begin
                    // blink: full color while (now/250) is even, else black
                    res_r_next = '0;
                    res_g_next = '0;
                    res_b_next = '0;
                    if (blink_on)
                    begin
                        case (mode_reg)
                            slcg_pkg::MODE_TURN:
                            begin
                                res_r_next = m;
                                res_g_next = slcg_pkg::pct45(m);
                            end
                            slcg_pkg::MODE_CHASE:
                            begin
                                res_g_next = m;
                                res_b_next = m;
                            end
                            slcg_pkg::MODE_SEQ:   res_g_next = m;
                            slcg_pkg::MODE_ALT:   res_r_next = m;
                            default: ;
                        endcase
                    end
                    ho_next    = HO_PENDING;
                    state_next = ST_IDLE;
                end
            end

            ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIV_END;
                end
            end

            ST_DIV_END:
            begin
                if (div_pass_reg)
                begin
                    // zero ceiling: red is forced to black instead of taking the quotient
                    res_r_next = (m == '0) ? '0 : q8;
                    ho_next    = HO_PENDING;
                    state_next = ST_IDLE;
                end
                else if (mode_reg == slcg_pkg::MODE_PULSE)
                begin
                    res_r_next    = '0;
                    res_g_next    = '0;
                    res_b_next    = q8;
                    cnt_next      = slcg_pkg::DIV_LAST_STEP;
                    div_pass_next = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    // breathing blue, green at half
                    res_r_next = '0;
                    res_g_next = {1'b0, q8[slcg_pkg::LVL_W-1:1]};
                    res_b_next = q8;
                    ho_next    = HO_PENDING;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ho_reg         <= HO_IDLE;
            cnt_reg        <= '0;
            div_pass_reg   <= 1'b0;
            now_reg        <= '0;
            mode_reg       <= slcg_pkg::MODE_MANUAL;
            client_reg     <= 1'b0;
            stop_on_reg    <= 1'b0;
            rev_on_reg     <= 1'b0;
            turn_on_reg    <= 1'b0;
            mark_on_reg    <= 1'b0;
            last_frame_reg <= '0;
            ovl_level_reg  <= '0;
            ovl_end_reg    <= '0;
            max_level_reg  <= slcg_pkg::MAX_LEVEL_RST;
            interval_reg   <= slcg_pkg::INTERVAL_RST;
            hold_reg       <= slcg_pkg::HOLD_RST;
            res_r_reg      <= '0;
            res_g_reg      <= '0;
            res_b_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ho_reg         <= ho_next;
            cnt_reg        <= cnt_next;
            div_pass_reg   <= div_pass_next;
            now_reg        <= now_next;
            mode_reg       <= mode_next;
            client_reg     <= client_next;
            stop_on_reg    <= stop_on_next;
            rev_on_reg     <= rev_on_next;
            turn_on_reg    <= turn_on_next;
            mark_on_reg    <= mark_on_next;
            last_frame_reg <= last_frame_next;
            ovl_level_reg  <= ovl_level_next;
            ovl_end_reg    <= ovl_end_next;
            max_level_reg  <= max_level_next;
            interval_reg   <= interval_next;
            hold_reg       <= hold_next;
            res_r_reg      <= res_r_next;
            res_g_reg      <= res_g_next;
            res_b_reg      <= res_b_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    // overlay word never starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_axis_tuser[0] == slcg_pkg::ACT_OVERLAY)) |=> (state_reg == ST_IDLE))
        else $error("overlay word started a color computation");

    // a color waiting for hand-off always belongs to the frame just stamped
    assert property (@(posedge clk) disable iff (!rst_n)
        (ho_reg == HO_PENDING) |-> (last_frame_reg == now_reg))
        else $error("pending color does not match last frame time");

    // second divider pass is only for pulse red
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && div_pass_reg) |-> (mode_reg == slcg_pkg::MODE_PULSE))
        else $error("second divide outside pulse mode");

    // stored overlay level is clamped
    assert property (@(posedge clk) disable iff (!rst_n)
        $changed(ovl_end_reg) |-> (ovl_level_reg <= slcg_pkg::PCT_FULL))
        else $error("overlay level above full scale");

endmodule

// ===== sv/slcg_mod_unit.sv =====
// Bit-serial remainder unit: value mod modulus, one dividend bit per cycle while step is high, MSB first.
// Depends on slcg_pkg.
module slcg_mod_unit (
    input  logic                        clk,
    input  slcg_pkg::mod_ctl_t          ctl,
    input  logic [slcg_pkg::NOW_W-1:0]  value,
    input  logic [slcg_pkg::REM_W-1:0]  modulus,
    output logic [slcg_pkg::REM_W-1:0]  remainder
);

    logic [slcg_pkg::NOW_W-1:0] shift_reg;
    logic [slcg_pkg::REM_W-1:0] rem_reg;
    logic [slcg_pkg::REM_W-1:0] rem_next;
    logic [slcg_pkg::REM_W:0]   partial;
    logic [slcg_pkg::REM_W:0]   reduced;

    always_comb
    begin
        partial = {rem_reg, shift_reg[slcg_pkg::NOW_W-1]};
        if (partial >= {1'b0, modulus})
        begin
            reduced = partial - {1'b0, modulus};
        end
        else
        begin
            reduced = partial;
        end
        rem_next = reduced[slcg_pkg::REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            shift_reg <= value;
            rem_reg   <= '0;
        end
        else if (ctl.step)
        begin
            shift_reg <= {shift_reg[slcg_pkg::NOW_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign remainder = rem_reg;

endmodule

// ===== sv/slcg_div_unit.sv =====
// Restoring bit-serial divider: one quotient bit per cycle while step is high, quotient shifts into the dividend.
// Depends on slcg_pkg.
module slcg_div_unit (
    input  logic                          clk,
    input  slcg_pkg::div_ctl_t            ctl,
    input  logic [slcg_pkg::DIV_Q_W-1:0]  dividend,
    input  logic [slcg_pkg::DIV_D_W-1:0]  divisor,
    output logic [slcg_pkg::DIV_Q_W-1:0]  quotient
);

    logic [slcg_pkg::DIV_Q_W-1:0] quo_reg;
    logic [slcg_pkg::DIV_D_W-1:0] rem_reg;
    logic [slcg_pkg::DIV_D_W-1:0] dvs_reg;
    logic [slcg_pkg::DIV_D_W-1:0] rem_next;
    logic [slcg_pkg::DIV_D_W:0]   partial;
    logic [slcg_pkg::DIV_D_W:0]   diff;
    logic                         ge;

    always_comb
    begin
        partial = {rem_reg, quo_reg[slcg_pkg::DIV_Q_W-1]};
        diff    = partial - {1'b0, dvs_reg};
        ge      = (partial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[slcg_pkg::DIV_D_W-1:0] : partial[slcg_pkg::DIV_D_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (ctl.step)
        begin
            quo_reg <= {quo_reg[slcg_pkg::DIV_Q_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;

endmodule
